>>> rtl/t2u_pkg.sv
// Shared constants, character codes and types of the text to u64 parser.
package t2u_pkg;

  // Sizes of the fields and of the character counter.
  localparam int MAX_OFFSET = 4095;
  localparam int CNT_W      = $clog2(MAX_OFFSET + 1);
  localparam int OFS_W      = 12;
  localparam int VAL_W      = 64;
  localparam int BASE_W     = 6;
  localparam int DIG_W      = 6;
  localparam int PROD_W     = VAL_W + BASE_W;

  // Character codes.
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  // Offsets that map letters to digit values ten and up.
  localparam logic [7:0] UP_DIG_OFS = CH_UP_A - 8'd10;
  localparam logic [7:0] LO_DIG_OFS = CH_LO_A - 8'd10;

  // Radix codes.
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_2    = 6'd2;
  localparam logic [BASE_W-1:0] BASE_8    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_10   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_16   = 6'd16;

  // Parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_WS     = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  // Parser state carried from one item to the next.
  typedef struct packed {
    phase_t             phase;
    logic [VAL_W-1:0]   acc;
    logic [BASE_W-1:0]  base;
    logic               minus;
    logic               ovf;
    logic               dseen;
    logic [CNT_W-1:0]   count;
  } t2u_state_t;

  // One conversion result.
  typedef struct packed {
    logic               overflowed;
    logic               any_digits;
    logic [OFS_W-1:0]   end_offset;
    logic [VAL_W-1:0]   value;
  } t2u_result_t;

endpackage

>>> rtl/t2u_step.sv
// Next-state and result logic for one character of the parser.
module t2u_step (
  input  t2u_pkg::t2u_state_t             cur,
  input  logic [7:0]                      ch,
  input  logic                            start,
  input  logic [t2u_pkg::BASE_W-1:0]      cfg_base,
  output t2u_pkg::t2u_state_t             nxt,
  output logic                            emit,
  output t2u_pkg::t2u_result_t            res
);
  import t2u_pkg::*;

  t2u_state_t         eff;
  t2u_state_t         nxt_pre;
  logic               is_space;
  logic               is_num;
  logic               is_upper;
  logic               is_lower;
  logic [DIG_W-1:0]   dval;
  logic               first_zero;
  logic               take_first;
  logic               do_digit;
  logic               dig_ok;
  logic [BASE_W-1:0]  dig_base;
  logic [VAL_W-1:0]   acc_in;
  logic               ovf_in;
  logic               dseen_in;
  logic [PROD_W-1:0]  prod;
  logic               ovf_now;

  // Character classes and digit value.
  always_comb begin
    is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    is_num   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
    is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
    if (is_num) begin
      dval = DIG_W'(ch - CH_ZERO);
    end else if (is_upper) begin
      dval = DIG_W'(ch - UP_DIG_OFS);
    end else begin
      dval = DIG_W'(ch - LO_DIG_OFS);
    end
  end

  // Phase decode: a start request restarts the state before the character is parsed.
  always_comb begin
    eff = cur;
    if (start) begin
      eff.phase = PH_WS;
      eff.acc   = '0;
      eff.base  = cfg_base;
      eff.minus = 1'b0;
      eff.ovf   = 1'b0;
      eff.dseen = 1'b0;
      eff.count = '0;
    end

    nxt_pre    = eff;
    do_digit   = 1'b0;
    take_first = 1'b0;
    dig_base   = eff.base;
    acc_in     = eff.acc;
    ovf_in     = eff.ovf;
    dseen_in   = eff.dseen;
    first_zero = (ch == CH_ZERO) &&
                 ((eff.base == BASE_AUTO) || (eff.base == BASE_16) || (eff.base == BASE_2));

    unique case (eff.phase)
      PH_WS: begin
        if (is_space) begin
          nxt_pre.phase = PH_WS;
        end else if (ch == CH_MINUS) begin
          nxt_pre.minus = 1'b1;
          nxt_pre.phase = PH_SIGNED;
        end else if (ch == CH_PLUS) begin
          nxt_pre.phase = PH_SIGNED;
        end else begin
          take_first = 1'b1;
        end
      end
      PH_SIGNED: begin
        take_first = 1'b1;
      end
      PH_ZERO: begin
        if (((ch == CH_LO_X) || (ch == CH_UP_X)) &&
            ((eff.base == BASE_AUTO) || (eff.base == BASE_16))) begin
          nxt_pre.base  = BASE_16;
          nxt_pre.phase = PH_DIGITS;
        end else if (((ch == CH_LO_B) || (ch == CH_UP_B)) &&
                     ((eff.base == BASE_AUTO) || (eff.base == BASE_2))) begin
          nxt_pre.base  = BASE_2;
          nxt_pre.phase = PH_DIGITS;
        end else begin
          // The leading zero counts as a digit of an octal or plain number.
          do_digit = 1'b1;
          dig_base = (eff.base == BASE_AUTO) ? BASE_8 : eff.base;
          acc_in   = '0;
          dseen_in = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
        nxt_pre.phase = eff.phase;
      end
    endcase

    // First significant character: a zero may open a prefix.
    if (take_first) begin
      if (first_zero) begin
        nxt_pre.phase = PH_ZERO;
      end else begin
        do_digit = 1'b1;
        dig_base = (eff.base == BASE_AUTO) ? BASE_10 : eff.base;
      end
    end
  end

  // Multiply-accumulate; the value overflows when the product leaves 64 bits.
  assign dig_ok  = (is_num || is_upper || is_lower) && (dval < dig_base);
  assign prod    = ({BASE_W'(0), acc_in} * {VAL_W'(0), dig_base}) + PROD_W'(dval);
  assign ovf_now = |prod[PROD_W-1:VAL_W];

  // Digit step or termination, then the character count.
  always_comb begin
    nxt  = nxt_pre;
    emit = 1'b0;
    if (do_digit) begin
      nxt.base  = dig_base;
      nxt.phase = PH_DIGITS;
      nxt.dseen = dseen_in;
      nxt.ovf   = ovf_in;
      nxt.acc   = acc_in;
      if (dig_ok) begin
        nxt.dseen = 1'b1;
        nxt.ovf   = ovf_in || ovf_now;
        if (!(ovf_in || ovf_now)) begin
          nxt.acc = prod[VAL_W-1:0];
        end
      end else begin
        emit      = 1'b1;
        nxt.phase = PH_IDLE;
      end
    end
    // Count characters of an open string up to the saturation limit.
    if ((eff.phase != PH_IDLE) && !emit && (eff.count < CNT_W'(MAX_OFFSET))) begin
      nxt.count = eff.count + CNT_W'(1);
    end
  end

  // Result fields as seen at the terminating character.
  always_comb begin
    if (ovf_in) begin
      res.value = '1;
    end else if (eff.minus) begin
      res.value = VAL_W'(0) - acc_in;
    end else begin
      res.value = acc_in;
    end
    res.end_offset = dseen_in ? OFS_W'(eff.count) : '0;
    res.any_digits = dseen_in;
    res.overflowed = ovf_in;
  end

endmodule

>>> rtl/t2u_out_fifo.sv
// Two-entry result buffer between the parser and the output channel.
module t2u_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  t2u_pkg::t2u_result_t  din,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_ready,
  output t2u_pkg::t2u_result_t  dout
);
  import t2u_pkg::*;

  t2u_result_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign dout      = mem[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // The buffer is never written while full, and occupancy stays in range.
  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("result buffer written while full");
  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer occupancy out of range");
  assert property (@(posedge clk) disable iff (rst)
                   (push && !pop) |=> (cnt == $past(cnt) + 2'd1))
    else $error("result buffer count missed a write");

endmodule

>>> rtl/text_to_u64_parser.sv
// Top level of the streaming text to unsigned 64-bit parser.
//
// Usage: characters enter on the s_ channel one item per character, the
// byte code in s_tdata and a start flag in s_tuser that opens a new string.
// Leading whitespace and one sign are skipped, a 0x or 0b prefix is taken,
// and digits below the radix are accumulated. The first character that is
// not a digit closes the string and produces one result item on the m_
// channel; strings that are restarted before they close give no result.
// The radix is written through cfg_wr_en/cfg_wr_data while the block is
// idle and is latched at each start; 0 selects it from the prefix.
// Throughput is one character per cycle while s_tready is high. The parse
// step is a single 64 x 6 multiply-add between the state registers and a
// two-entry result buffer, so a result is in the buffer in the cycle after its
// terminating character is accepted. When the receiver stalls, up to two
// results are held and s_tready drops only when both entries are occupied.
// Reset sets the radix to ten, closes any open string and empties the buffer.
module text_to_u64_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [t2u_pkg::BASE_W-1:0] cfg_wr_data,  // number_base
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,      // ch
  input  logic [0:0]                 s_tuser,      // start_req
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [79:0]                m_tdata,      // value, end_offset, zero fill
  output logic [1:0]                 m_tuser       // any_digits, overflowed
);
  import t2u_pkg::*;

  logic [BASE_W-1:0] number_base;
  t2u_state_t        st;
  t2u_state_t        st_next;
  logic              emit;
  logic              accept;
  logic              push;
  logic              full;
  t2u_result_t       res;
  t2u_result_t       out_res;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !full;
  assign push     = accept && emit;

  // Parse step for the character on the input channel.
  t2u_step u_step (
    .cur      (st),
    .ch       (s_tdata),
    .start    (s_tuser[0]),
    .cfg_base (number_base),
    .nxt      (st_next),
    .emit     (emit),
    .res      (res)
  );

  // Radix register and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_10;
      st.phase    <= PH_IDLE;
      st.acc      <= '0;
      st.base     <= '0;
      st.minus    <= 1'b0;
      st.ovf      <= 1'b0;
      st.dseen    <= 1'b0;
      st.count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        number_base <= cfg_wr_data;
      end
      if (accept) begin
        st <= st_next;
      end
    end
  end

  // Result buffer and output packing.
  t2u_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (out_res)
  );

  assign m_tdata = {4'b0000, out_res.end_offset, out_res.value};
  assign m_tuser = {out_res.overflowed, out_res.any_digits};

  // A result closes the string; a flagged overflow reads all ones; no digits reads zero.
  assert property (@(posedge clk) disable iff (rst) push |=> (st.phase == PH_IDLE))
    else $error("string still open after its result");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && m_tuser[1]) |-> (m_tdata[63:0] == '1))
    else $error("overflow result is not all ones");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tuser[0]) |-> ((m_tdata[75:0] == '0) && !m_tuser[1]))
    else $error("result without digits is not zero");

endmodule

>>> sim/text_to_u64_parser_tb.sv
// Self-checking testbench for the streaming text to unsigned 64-bit parser.
`timescale 1ns / 1ps

module text_to_u64_parser_tb;
  import t2u_pkg::*;

  localparam int          IDLE_LIMIT  = 4000;  // cycles with no item moving on either side
  localparam int          HOLD_CYCLES = 300;   // one long receiver stall
  localparam int          HOLD_AFTER  = 40;    // results seen before that stall starts
  localparam int          PHASE_ITEMS = 170;   // random items per radix setting
  localparam int          N_DIRECTED  = 31;
  localparam logic [63:0] ALL_ONES    = '1;

  // Scan position within one string.
  typedef enum logic [5:0] {
    SCAN_IDLE   = 6'b000001,
    SCAN_WS     = 6'b000010,
    SCAN_SIGN   = 6'b000100,
    SCAN_ZERO   = 6'b001000,
    SCAN_PREFIX = 6'b010000,
    SCAN_DIGITS = 6'b100000
  } scan_t;

  // One directed item, with the result typed in where it is obvious.
  typedef struct {
    logic [7:0]  c;
    logic        st;
    bit          set_radix;
    logic [5:0]  radix;
    bit          typed;
    logic [63:0] v;
    logic [11:0] ofs;
    logic        anyd;
    logic        ovf;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = BASE_10;  // number_base
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;         // ch
  logic [0:0]  s_tuser = 1'b0;         // start_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;                // value, end_offset, zero fill
  logic [1:0]  m_tuser;                // any_digits, overflowed

  // Predicted parser state and the radix register as last written.
  scan_t            scan;
  logic [63:0]      num_acc;
  logic [5:0]       num_radix;
  logic             num_neg;
  logic             num_ovf;
  logic             num_seen;
  logic [CNT_W-1:0] num_count;
  logic [5:0]       cfg_radix;

  t2u_result_t conv_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          live_items = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;

  // Columns: char, start, write radix, radix, typed, value, offset, any digits, overflow.
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{"a",      1'b0, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"5",      1'b1, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"!",      1'b0, 1'b0, BASE_10, 1'b1, 64'd5,    12'd1, 1'b1, 1'b0},
    '{CH_TAB,   1'b1, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{CH_MINUS, 1'b0, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"1",      1'b0, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{CH_SPACE, 1'b0, 1'b0, BASE_10, 1'b1, ALL_ONES, 12'd3, 1'b1, 1'b0},
    '{CH_PLUS,  1'b1, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{CH_LO_X,  1'b0, 1'b0, BASE_10, 1'b1, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"9",      1'b1, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"1",      1'b1, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"2",      1'b0, 1'b0, BASE_10, 1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{8'hFF,    1'b0, 1'b0, BASE_10, 1'b1, 64'd12,   12'd2, 1'b1, 1'b0},
    '{8'h00,    1'b1, 1'b0, BASE_10, 1'b1, 64'd0,    12'd0, 1'b0, 1'b0},
    '{CH_ZERO,  1'b1, 1'b1, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{CH_UP_X,  1'b0, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{"1",      1'b0, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{"f",      1'b0, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{".",      1'b0, 1'b0, BASE_AUTO, 1'b1, 64'd31, 12'd4, 1'b1, 1'b0},
    '{CH_ZERO,  1'b1, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{CH_LO_B,  1'b0, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{"2",      1'b0, 1'b0, BASE_AUTO, 1'b1, 64'd0,  12'd0, 1'b0, 1'b0},
    '{CH_ZERO,  1'b1, 1'b0, BASE_AUTO, 1'b0, 64'd0,  12'd0, 1'b0, 1'b0},
    '{"8",      1'b0, 1'b0, BASE_AUTO, 1'b1, 64'd0,  12'd1, 1'b1, 1'b0},
    '{"Z",      1'b1, 1'b1, 6'd36,   1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"z",      1'b0, 1'b0, 6'd36,   1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"~",      1'b0, 1'b0, 6'd36,   1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{CH_ZERO,  1'b1, 1'b1, 6'd1,    1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"1",      1'b0, 1'b0, 6'd1,    1'b1, 64'd0,    12'd1, 1'b1, 1'b0},
    '{"z",      1'b1, 1'b1, 6'd63,   1'b0, 64'd0,    12'd0, 1'b0, 1'b0},
    '{"~",      1'b0, 1'b0, 6'd63,   1'b1, 64'd35,   12'd1, 1'b1, 1'b0}
  };

  // Radix settings of the random phases; the last phase picks one from 38 to 62.
  logic [5:0] phase_radix [9] = '{
    BASE_10, BASE_AUTO, BASE_16, BASE_2, BASE_8, 6'd36, 6'd63, 6'd1, 6'd37
  };

  text_to_u64_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Digit value of a letter or numeral; anything else can never be a digit.
  function automatic int digit_of(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - UP_DIG_OFS);
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - LO_DIG_OFS);
    return 99;
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? LO_DIG_OFS : UP_DIG_OFS) + 8'(d);
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
  endfunction

  // Close the open string and form its result.
  task automatic seal_result(output t2u_result_t r);
    r.value      = num_ovf ? ALL_ONES : (num_neg ? 64'd0 - num_acc : num_acc);
    r.end_offset = num_seen ? OFS_W'(num_count) : 12'd0;
    r.any_digits = num_seen;
    r.overflowed = num_ovf;
    scan = SCAN_IDLE;
  endtask

  // Accumulate one digit with a sticky overflow, or end the string on a non-digit.
  task automatic add_digit(input logic [7:0] c, output bit closed, output t2u_result_t r);
    int          d;
    logic [63:0] b;
    logic [63:0] lim;
    logic [63:0] rem;
    d = digit_of(c);
    b = 64'(num_radix);
    closed = 1'b0;
    r = '0;
    if (d >= int'(num_radix)) begin
      seal_result(r);
      closed = 1'b1;
    end else begin
      lim = ALL_ONES / b;
      rem = ALL_ONES % b;
      if (num_ovf || num_acc > lim || (num_acc == lim && 64'(d) > rem)) begin
        num_ovf = 1'b1;
      end else begin
        num_acc = num_acc * b + 64'(d);
      end
      num_seen = 1'b1;
    end
  endtask

  // First character after whitespace and sign: a zero may open a prefix.
  task automatic first_char(input logic [7:0] c, output bit closed, output t2u_result_t r);
    closed = 1'b0;
    r = '0;
    if (c == CH_ZERO &&
        (num_radix == BASE_AUTO || num_radix == BASE_16 || num_radix == BASE_2)) begin
      scan = SCAN_ZERO;
    end else begin
      if (num_radix == BASE_AUTO) num_radix = BASE_10;
      scan = SCAN_DIGITS;
      add_digit(c, closed, r);
    end
  endtask

  // Character after a leading zero: hex or binary prefix, else the zero was a digit.
  task automatic after_zero(input logic [7:0] c, output bit closed, output t2u_result_t r);
    bit unused;
    closed = 1'b0;
    r = '0;
    if ((c == CH_LO_X || c == CH_UP_X) && (num_radix == BASE_AUTO || num_radix == BASE_16)) begin
      num_radix = BASE_16;
      scan = SCAN_PREFIX;
    end else if ((c == CH_LO_B || c == CH_UP_B) &&
                 (num_radix == BASE_AUTO || num_radix == BASE_2)) begin
      num_radix = BASE_2;
      scan = SCAN_PREFIX;
    end else begin
      if (num_radix == BASE_AUTO) num_radix = BASE_8;
      scan = SCAN_DIGITS;
      add_digit(CH_ZERO, unused, r);
      add_digit(c, closed, r);
    end
  endtask

  // Advance the predicted parser by one accepted item.
  task automatic parse_char(input logic [7:0] c, input logic st,
                            output bit closed, output t2u_result_t r);
    bit live;
    closed = 1'b0;
    r = '0;
    if (st) begin
      scan      = SCAN_WS;
      num_acc   = 64'd0;
      num_radix = cfg_radix;
      num_neg   = 1'b0;
      num_ovf   = 1'b0;
      num_seen  = 1'b0;
      num_count = '0;
    end
    live = (scan != SCAN_IDLE);
    case (scan)
      SCAN_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // leading whitespace is skipped
        end else if (c == CH_MINUS) begin
          num_neg = 1'b1;
          scan = SCAN_SIGN;
        end else if (c == CH_PLUS) begin
          scan = SCAN_SIGN;
        end else begin
          first_char(c, closed, r);
        end
      end
      SCAN_SIGN: first_char(c, closed, r);
      SCAN_ZERO: after_zero(c, closed, r);
      SCAN_PREFIX, SCAN_DIGITS: add_digit(c, closed, r);
      default: ;
    endcase
    if (live && !closed && num_count < CNT_W'(MAX_OFFSET)) num_count = num_count + CNT_W'(1);
  endtask

  // Offer one item, wait for it to be taken, then predict what it causes.
  task automatic send_char(input logic [7:0] c, input logic st, input bit typed,
                           input t2u_result_t fixed);
    int          gap;
    bit          closed;
    t2u_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= st;
    do @(posedge clk); while (!s_tready);
    if (st || scan != SCAN_IDLE) live_items++;
    parse_char(c, st, closed, r);
    if (typed) begin
      conv_q.push_back(fixed);
    end else if (closed) begin
      conv_q.push_back(r);
    end
  endtask

  // Close any open string and wait until the block has nothing left to deliver.
  task automatic settle();
    if (scan != SCAN_IDLE) send_char("!", 1'b0, 1'b0, '0);
    s_tvalid <= 1'b0;
    while (conv_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_radix = b;
  endtask

  // One random string: mostly well formed with random content, some noise.
  task automatic send_number_string();
    logic [7:0]  txt[$];
    int          r;
    int          eb;
    int          pool;
    int          ndig;
    int          pos;
    int          rs;
    logic [63:0] n;
    logic [63:0] lim;
    logic [63:0] rem;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4))
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
    end else begin
      repeat ($urandom_range(0, 2)) txt.push_back(pick_space());
      r = $urandom_range(0, 9);
      if (r < 2) begin
        txt.push_back(CH_MINUS);
      end else if (r < 3) begin
        txt.push_back(CH_PLUS);
      end

      // Prefix, and the radix the digits will be read in.
      eb = int'(cfg_radix);
      if (cfg_radix == BASE_AUTO) begin
        r = $urandom_range(0, 3);
        eb = (r == 0) ? 16 : (r == 1) ? 2 : (r == 2) ? 8 : 10;
        if (r < 3) txt.push_back(CH_ZERO);
        if (r == 0) txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        if (r == 1) txt.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
      end else if (cfg_radix == BASE_16 && $urandom_range(0, 1)) begin
        txt.push_back(CH_ZERO);
        txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      end else if (cfg_radix == BASE_2 && $urandom_range(0, 1)) begin
        txt.push_back(CH_ZERO);
        txt.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
      end
      pool = (eb > 36) ? 36 : eb;

      if (eb >= 2 && eb <= 36 && $urandom_range(0, 99) < 10) begin
        // Digits that land on or just above the overflow cutoff, then one more digit.
        lim = ALL_ONES / 64'(eb);
        rem = ALL_ONES % 64'(eb);
        r = $urandom_range(0, 2);
        n = (r == 2) ? lim + 64'd1 : lim;
        pos = txt.size();
        do begin
          txt.insert(pos, digit_char(int'(n % 64'(eb))));
          n = n / 64'(eb);
        end while (n != 0);
        if (r == 0) begin
          txt.push_back(digit_char(int'(rem)));
        end else if (r == 1) begin
          txt.push_back(digit_char((int'(rem) + 1 < eb) ? int'(rem) + 1 : int'(rem)));
        end else begin
          txt.push_back(digit_char($urandom_range(0, pool - 1)));
        end
      end else begin
        r = $urandom_range(0, 99);
        ndig = (r < 65) ? $urandom_range(1, 6) :
               (r < 90) ? $urandom_range(7, 24) : $urandom_range(25, 70);
        repeat (ndig) txt.push_back(digit_char($urandom_range(0, pool - 1)));
      end

      // Terminator; left out now and then so the next start abandons this string.
      r = $urandom_range(0, 9);
      if (r < 4) begin
        txt.push_back(CH_SPACE);
      end else if (r < 6) begin
        txt.push_back("!");
      end else if (r < 9) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end

      rs = 0;
      if (txt.size() > 1 && $urandom_range(0, 19) == 0) rs = $urandom_range(1, txt.size() - 1);
      foreach (txt[i]) send_char(txt[i], i == 0 || (rs != 0 && i == rs), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each delivered result with the oldest prediction.
  always @(posedge clk) begin
    t2u_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (conv_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, value %0h", $time, m_tdata[63:0]);
      end else begin
        want = conv_q.pop_front();
        check_field("value", want.value, m_tdata[63:0]);
        check_field("end_offset", 64'(want.end_offset), 64'(m_tdata[75:64]));
        check_field("any_digits", 64'(want.any_digits), 64'(m_tuser[0]));
        check_field("overflowed", 64'(want.overflowed), 64'(m_tuser[1]));
      end
    end
  end

  // Give up when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin : sink
    int stall;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sender: directed items, then random phases over several radix settings.
  initial begin : stim
    t2u_result_t fixed;
    int          mark;
    logic [5:0]  radix;
    scan      = SCAN_IDLE;
    num_acc   = 64'd0;
    num_radix = 6'd0;
    num_neg   = 1'b0;
    num_ovf   = 1'b0;
    num_seen  = 1'b0;
    num_count = '0;
    cfg_radix = BASE_10;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_radix) begin
        settle();
        write_radix(dir_tab[i].radix);
      end
      fixed.value      = dir_tab[i].v;
      fixed.end_offset = dir_tab[i].ofs;
      fixed.any_digits = dir_tab[i].anyd;
      fixed.overflowed = dir_tab[i].ovf;
      send_char(dir_tab[i].c, dir_tab[i].st, dir_tab[i].typed, fixed);
    end

    for (int p = 0; p < 10; p++) begin
      radix = (p < 9) ? phase_radix[p] : 6'($urandom_range(38, 62));
      settle();
      write_radix(radix);
      steady = (p == 2 || p == 6);
      mark = live_items;
      while (live_items - mark < PHASE_ITEMS) send_number_string();
    end

    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
